### rtl/core/vconv_pkg.sv
// Shared types and constants for the valid-mode 2D convolution block.
package vconv_pkg;

    localparam int K_MAX  = 8;
    localparam int SMP_W  = 16;
    localparam int PROD_W = 2 * SMP_W;
    localparam int CSUM_W = PROD_W + $clog2(K_MAX);
    localparam int PAIR_W = CSUM_W + 1;
    localparam int SUM_W  = 38;
    localparam int KR_W   = 4;
    localparam int CIDX_W = 6;
    localparam int ROW_W  = 16;
    localparam int OCOL_W = 10;
    localparam int CFGD_W = 16;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef t_smp [K_MAX-1:0]        t_col;
    typedef t_smp [K_MAX-2:0]        t_line;

    typedef enum logic {
        FUNC_COEF  = 1'b0,
        FUNC_PIXEL = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        CFG_IMG_WIDTH  = 2'd0,
        CFG_IMG_HEIGHT = 2'd1,
        CFG_KER_ROWS   = 2'd2,
        CFG_KER_COLS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              emit;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } t_meta;

endpackage

### rtl/core/vconv_cell.sv
// One window column: holds K_MAX samples, multiplies by its coefficients, sums the column.
module vconv_cell
    import vconv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_shift,
    input  t_col                     i_col,
    input  t_col                     i_coef,
    output t_col                     o_col,
    output logic signed [CSUM_W-1:0] o_sum
);

    t_col                     r_col;
    logic signed [PROD_W-1:0] r_prod [K_MAX];
    logic signed [CSUM_W-1:0] r_sum;
    logic signed [CSUM_W-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en && i_shift) begin
            r_col <= i_col;
        end
    end

    // product stage, then column sum stage; taps outside the kernel add nothing,
    // whatever stale line data sits in them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < K_MAX; k++) begin
                if (i_coef[k] == '0) begin
                    r_prod[k] <= '0;
                end else begin
                    r_prod[k] <= $signed(r_col[k]) * $signed(i_coef[k]);
                end
            end
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < K_MAX; k++) begin
            n_sum = n_sum + CSUM_W'(r_prod[k]);
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

### rtl/core/valid_2d_convolution.sv
// Streaming valid-mode 2D correlation (no kernel flip): a chain of column cells over line buffers.
//
// Coefficients are loaded with func=0 (index row*8+col) into a store cleared at reset; image
// samples follow in raster order with func=1. One request is taken per clock: a raster column
// read from the line-buffer RAM (one read and one write port, registered read data, a one-entry
// write bypass for back-to-back hits on the same column) feeds a row of eight column cells that
// shift left every sample. Each cell multiplies its eight samples by the aligned kernel and sums
// them; a two-stage adder tree finishes the exact Q.30 sum. Throughput is one sample per clock,
// limited only by output stall. Configuration writes are expected while the block is idle.
module valid_2d_convolution
    import vconv_pkg::*;
#(
    parameter int MAXW = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input requests
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_func,
    input  logic [CIDX_W-1:0]       i_coef_index,
    input  logic signed [SMP_W-1:0] i_value,
    // results
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_conv_sum,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [OCOL_W-1:0]       o_out_col,
    output logic                    o_last,
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFGD_W-1:0]       i_cfg_data
);

    localparam int CW = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int LW = (K_MAX - 1) * SMP_W;

    // ---------------- configuration ----------------
    logic [10:0]      r_img_width;
    logic [ROW_W-1:0] r_img_height;
    logic [KR_W-1:0]  r_ker_rows;
    logic [KR_W-1:0]  r_ker_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= 11'd1024;
            r_img_height <= 16'd1024;
            r_ker_rows   <= 4'd3;
            r_ker_cols   <= 4'd3;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[10:0];
                CFG_IMG_HEIGHT: r_img_height <= i_cfg_data;
                CFG_KER_ROWS:   r_ker_rows   <= i_cfg_data[KR_W-1:0];
                CFG_KER_COLS:   r_ker_cols   <= i_cfg_data[KR_W-1:0];
                default:        r_img_width  <= r_img_width;
            endcase
        end
    end

    // clamped sizes
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [KR_W-1:0]  kr_eff;
    logic [KR_W-1:0]  kc_eff;

    always_comb begin
        if (r_img_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_img_width) > WW'(MAXW)) begin
            w_eff = WW'(MAXW);
        end else begin
            w_eff = WW'(r_img_width);
        end
        h_eff  = (r_img_height == '0) ? ROW_W'(1) : r_img_height;
        kr_eff = (r_ker_rows == '0) ? KR_W'(1) :
                 (r_ker_rows > KR_W'(K_MAX)) ? KR_W'(K_MAX) : r_ker_rows;
        kc_eff = (r_ker_cols == '0) ? KR_W'(1) :
                 (r_ker_cols > KR_W'(K_MAX)) ? KR_W'(K_MAX) : r_ker_cols;
    end

    // ---------------- pipeline control ----------------
    logic  en;
    logic  in_acc;
    t_meta r_o_meta;

    assign en      = !r_o_meta.emit || !i_stall;
    assign o_stall = !en;
    assign in_acc  = i_valid && en;

    // ---------------- raster counters ----------------
    logic [ROW_W-1:0] r_row_cnt;
    logic [CW-1:0]    r_col_cnt;
    logic [ROW_W:0]   row_p1;
    logic [WW-1:0]    col_p1;
    t_meta            in_meta;

    assign row_p1 = {1'b0, r_row_cnt} + (ROW_W+1)'(1);
    assign col_p1 = WW'(r_col_cnt) + WW'(1);

    always_comb begin
        in_meta.emit = ({1'b0, r_row_cnt} < {1'b0, h_eff}) && (WW'(r_col_cnt) < w_eff) &&
                       (row_p1 >= (ROW_W+1)'(kr_eff)) && (col_p1 >= WW'(kc_eff));
        in_meta.row  = ROW_W'(row_p1 - (ROW_W+1)'(kr_eff));
        in_meta.col  = OCOL_W'(col_p1 - WW'(kc_eff));
        in_meta.last = (r_row_cnt == h_eff - ROW_W'(1)) && (WW'(r_col_cnt) == w_eff - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (in_acc && t_func'(i_func) == FUNC_PIXEL) begin
            if (col_p1 >= w_eff) begin
                r_col_cnt <= '0;
                r_row_cnt <= (row_p1 >= (ROW_W+1)'(h_eff)) ? '0 : ROW_W'(row_p1);
            end else begin
                r_col_cnt <= CW'(col_p1);
            end
        end
    end

    // ---------------- stage 1: request + line buffer read ----------------
    logic              r_s1_vld;
    t_func             r_s1_func;
    logic [CIDX_W-1:0] r_s1_idx;
    t_smp              r_s1_val;
    logic [CW-1:0]     r_s1_addr;
    t_meta             r_s1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_meta <= '0;
        end else if (en) begin
            r_s1_vld  <= i_valid;
            r_s1_meta <= (i_valid && t_func'(i_func) == FUNC_PIXEL) ? in_meta : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= t_func'(i_func);
            r_s1_idx  <= i_coef_index;
            r_s1_val  <= i_value;
            r_s1_addr <= r_col_cnt;
        end
    end

    logic          pix_go;
    logic [LW-1:0] r_line_mem [MAXW];
    logic [LW-1:0] r_line_rd;
    logic [LW-1:0] r_lw_data;
    logic [CW-1:0] r_lw_addr;
    logic          r_lw_vld;
    t_line         line_old;
    t_line         line_new;

    assign pix_go = en && r_s1_vld && r_s1_func == FUNC_PIXEL;

    // column of the line buffer: oldest row first
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_rd <= r_line_mem[r_col_cnt];
        end
        if (pix_go) begin
            r_line_mem[r_s1_addr] <= line_new;
        end
    end

    // bypass the write landing in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_vld <= 1'b0;
        end else if (pix_go) begin
            r_lw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= line_new;
        end
    end

    always_comb begin
        line_old = (r_lw_vld && r_lw_addr == r_s1_addr) ? t_line'(r_lw_data) : t_line'(r_line_rd);
        for (int k = 0; k < K_MAX - 2; k++) begin
            line_new[k] = line_old[k+1];
        end
        line_new[K_MAX-2] = r_s1_val;
    end

    // ---------------- coefficient store ----------------
    t_smp r_coef [K_MAX*K_MAX];
    t_col r_acoef [K_MAX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < K_MAX * K_MAX; i++) begin
                r_coef[i] <= '0;
            end
        end else if (en && r_s1_vld && r_s1_func == FUNC_COEF) begin
            r_coef[r_s1_idx] <= r_s1_val;
        end
    end

    // kernel aligned to the bottom-right corner of the window
    always_ff @(posedge i_clk) begin
        for (int wc = 0; wc < K_MAX; wc++) begin
            for (int wr = 0; wr < K_MAX; wr++) begin
                if (wr + int'(kr_eff) >= K_MAX && wc + int'(kc_eff) >= K_MAX) begin
                    r_acoef[wc][wr] <= r_coef[(wr + int'(kr_eff) - K_MAX) * K_MAX
                                              + wc + int'(kc_eff) - K_MAX];
                end else begin
                    r_acoef[wc][wr] <= '0;
                end
            end
        end
    end

    // ---------------- window: chain of column cells ----------------
    t_col                     new_col;
    t_col                     cell_out [K_MAX];
    logic signed [CSUM_W-1:0] cell_sum [K_MAX];

    always_comb begin
        for (int k = 0; k < K_MAX - 1; k++) begin
            new_col[k] = line_old[k];
        end
        new_col[K_MAX-1] = r_s1_val;
    end

    for (genvar wc = 0; wc < K_MAX; wc++) begin : g_cell
        vconv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (pix_go),
            .i_col   ((wc == K_MAX - 1) ? new_col : cell_out[(wc + 1) % K_MAX]),
            .i_coef  (r_acoef[wc]),
            .o_col   (cell_out[wc]),
            .o_sum   (cell_sum[wc])
        );
    end

    // ---------------- adder tree and metadata ----------------
    t_meta                    r_m2, r_m3, r_m4, r_m5;
    logic signed [PAIR_W-1:0] r_pair [K_MAX/2];
    logic signed [SUM_W-1:0]  n_total;
    logic signed [SUM_W-1:0]  r_o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2     <= '0;
            r_m3     <= '0;
            r_m4     <= '0;
            r_m5     <= '0;
            r_o_meta <= '0;
        end else if (en) begin
            r_m2     <= r_s1_meta;
            r_m3     <= r_m2;
            r_m4     <= r_m3;
            r_m5     <= r_m4;
            r_o_meta <= r_m5;
        end
    end

    always_comb begin
        n_total = '0;
        for (int i = 0; i < K_MAX / 2; i++) begin
            n_total = n_total + SUM_W'(r_pair[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < K_MAX / 2; i++) begin
                r_pair[i] <= PAIR_W'(cell_sum[2*i]) + PAIR_W'(cell_sum[2*i+1]);
            end
            r_o_sum <= n_total;
        end
    end

    assign o_valid    = r_o_meta.emit;
    assign o_conv_sum = r_o_sum;
    assign o_out_row  = r_o_meta.row;
    assign o_out_col  = r_o_meta.col;
    assign o_last     = r_o_meta.last;

    // ---------------- assertions ----------------
    a_hold_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while a result is stalled");

    a_emit_is_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_meta.emit) |-> (r_s1_func == FUNC_PIXEL))
        else $error("coefficient request marked as producing a result");

    a_col_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col_cnt) < w_eff || $past(WW'(r_col_cnt)) >= $past(w_eff) ||
        $past(i_cfg_valid))
        else $error("column counter ran past the row width");

endmodule
